/* hw/rtl/wme_pkg.sv */
// ----------------------------------------------------------------------------
// wme_pkg: shared types and constants of the min/max envelope block
// Widths, register indexes and the divider request/response structs.
// ----------------------------------------------------------------------------
package wme_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 16;

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NC_W   = 4;
  localparam int BKT_W  = 16;
  localparam int FRM_W  = 32;
  localparam int PROD_W = FRM_W + BKT_W;

  // Channel sum and its magnitude.
  localparam int SUM_W = SAMPLE_BITS + CH_W;
  localparam int MAG_W = SUM_W;

  // Shared divider: low dividend bits shifted through the quotient register.
  localparam int DVD_W  = (MAG_W > BKT_W) ? MAG_W : BKT_W;
  localparam int STEP_W = $clog2(DVD_W + 1);

  localparam int FULL_SCALE_I = 2 ** (SAMPLE_BITS - 1) - 1;

  localparam int RESULT_LIMIT = 64;
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

  // Configuration port.
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES   = 2'd2;

  localparam logic [NC_W-1:0]  CHANNELS_RST = 4'd2;
  localparam logic [BKT_W-1:0] BUCKETS_RST  = 16'd1024;
  localparam logic [FRM_W-1:0] FRAMES_RST   = 32'd48000;

  typedef struct packed {
    logic              start;
    logic [FRM_W-1:0]  rem_init;
    logic [DVD_W-1:0]  dvd_init;
    logic [FRM_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

endpackage

/* hw/rtl/wme_in_if.sv */
// ----------------------------------------------------------------------------
// wme_in_if: frame channel of the envelope block
// Valid/ready channel carrying one frame of channel samples per beat.
// ----------------------------------------------------------------------------
interface wme_in_if import wme_pkg::*; ();

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_0;
  logic signed [SAMPLE_BITS-1:0] sample_1;
  logic signed [SAMPLE_BITS-1:0] sample_2;
  logic signed [SAMPLE_BITS-1:0] sample_3;
  logic signed [SAMPLE_BITS-1:0] sample_4;
  logic signed [SAMPLE_BITS-1:0] sample_5;
  logic signed [SAMPLE_BITS-1:0] sample_6;
  logic signed [SAMPLE_BITS-1:0] sample_7;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    input  ready
  );

  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    output ready
  );

endinterface

/* hw/rtl/wme_out_if.sv */
// ----------------------------------------------------------------------------
// wme_out_if: envelope result channel
// Valid/ready channel carrying one envelope point per beat.
// ----------------------------------------------------------------------------
interface wme_out_if import wme_pkg::*; ();

  logic                          valid;
  logic                          ready;
  logic [BKT_W-1:0]              bucket_index;
  logic signed [SAMPLE_BITS-1:0] min_value;
  logic signed [SAMPLE_BITS-1:0] max_value;
  logic                          filled;
  logic                          final_bucket;
  logic                          run_last;
  logic                          overflow;

  modport source (
    output valid, bucket_index, min_value, max_value, filled,
           final_bucket, run_last, overflow,
    input  ready
  );

  modport sink (
    input  valid, bucket_index, min_value, max_value, filled,
           final_bucket, run_last, overflow,
    output ready
  );

endinterface

/* hw/rtl/wme_div.sv */
// ----------------------------------------------------------------------------
// wme_div: shared restoring divider
// One quotient bit per cycle; the step count is given with each request.
// ----------------------------------------------------------------------------
module wme_div import wme_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [FRM_W-1:0]  rem;
  logic [FRM_W-1:0]  dvs;
  logic [DVD_W-1:0]  quo;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;

  logic [FRM_W:0]   trial;
  logic [FRM_W+1:0] diff;
  logic             qbit;

  // Shift in the next dividend bit, subtract when it fits.
  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvs};
    qbit  = ~diff[FRM_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (steps == STEP_W'(1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= req.rem_init;
      quo   <= req.dvd_init;
      dvs   <= req.divisor;
      steps <= req.steps;
    end else if (busy) begin
      rem   <= qbit ? diff[FRM_W-1:0] : trial[FRM_W-1:0];
      quo   <= {quo[DVD_W-2:0], qbit};
      steps <= steps - STEP_W'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

/* hw/rtl/waveform_minmax_envelope.sv */
// ----------------------------------------------------------------------------
// waveform_minmax_envelope: min/max peak decimation of a PCM frame stream
// Steps: a frame is summed over nc channels (nc = channels averaged), then
//   placed in a bucket; then one result per cycle while taken.
// Flow: no new frame is accepted until its results are out; the shared
//   divider runs twice per frame (mono average, then bucket placement).
// Reset: synchronous; loads the register defaults and restarts the stream.
// ----------------------------------------------------------------------------
module waveform_minmax_envelope import wme_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  wme_in_if.sink               samples,
  wme_out_if.source            results
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a frame beat
  localparam logic [2:0] S_SUM   = 3'd1;  // accumulate one channel per cycle
  localparam logic [2:0] S_MGO   = 3'd2;  // launch sum / channel count
  localparam logic [2:0] S_MWAIT = 3'd3;
  localparam logic [2:0] S_BGO   = 3'd4;  // launch position*buckets / frames
  localparam logic [2:0] S_BWAIT = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;  // fold the frame into the bucket
  localparam logic [2:0] S_EMIT  = 3'd7;  // emit closed/trailing buckets

  logic [2:0] state;

  // Configuration registers.
  logic [NC_W-1:0]  chan_cfg;
  logic [BKT_W-1:0] bkt_cfg;
  logic [FRM_W-1:0] frm_cfg;
  logic             cfg_hit;

  // Effective settings: zero counts act as one, channels saturate.
  logic [NC_W-1:0]  nc_eff;
  logic [BKT_W-1:0] nb_eff;
  logic [FRM_W-1:0] nf_eff;

  // Stream state.
  logic [FRM_W-1:0]              pos;
  logic [PROD_W-1:0]             prod;      // pos * nb_eff, kept by adding
  logic [BKT_W-1:0]              open_bkt;
  logic signed [SAMPLE_BITS-1:0] run_min;
  logic signed [SAMPLE_BITS-1:0] run_max;
  logic                          finished;

  // Per-frame work registers.
  logic signed [SAMPLE_BITS-1:0] smp [MAX_CHANNELS];
  logic [CH_W-1:0]               ch;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SAMPLE_BITS-1:0] mono;
  logic [BKT_W-1:0]              bkt;

  // Emit sequencer registers.
  logic                          phase_b;   // trailing run after last frame
  logic                          last_f;
  logic [BKT_W-1:0]              idx;
  logic [BKT_W-1:0]              seg_start;
  logic [BKT_W-1:0]              seg_end;
  logic signed [SAMPLE_BITS-1:0] seg_min;
  logic signed [SAMPLE_BITS-1:0] seg_max;
  logic [CNT_W-1:0]              n_tot;
  logic [CNT_W-1:0]              cnt;
  logic                          ovf;

  // Result register.
  logic                          ovalid;
  logic [BKT_W-1:0]              res_index;
  logic signed [SAMPLE_BITS-1:0] res_min;
  logic signed [SAMPLE_BITS-1:0] res_max;
  logic                          res_filled;
  logic                          res_final;
  logic                          res_run_last;
  logic                          res_ovf;

  // Shared divider.
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc;

  // Combinational helpers.
  logic [MAG_W-1:0]              sum_mag;
  logic [MAG_W-1:0]              q_mag;
  logic signed [SAMPLE_BITS-1:0] mono_mag;
  logic signed [SAMPLE_BITS-1:0] mono_val;
  logic [BKT_W-1:0]              bq;
  logic [BKT_W-1:0]              b_clamp;
  logic                          adv;
  logic                          last;
  logic [BKT_W-1:0]              open_new;
  logic [BKT_W-1:0]              a_cnt;
  logic [BKT_W-1:0]              b_cnt;
  logic [BKT_W:0]                total;
  logic [CNT_W-1:0]              n_sel;
  logic signed [SAMPLE_BITS-1:0] min_upd;
  logic signed [SAMPLE_BITS-1:0] max_upd;
  logic                          load;
  logic [BKT_W-1:0]              idx_inc;
  logic                          seg_done;

  wme_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_hit = cfg_we && ((cfg_index == CFG_CHANNELS) ||
                              (cfg_index == CFG_BUCKETS) ||
                              (cfg_index == CFG_FRAMES));

  always_comb begin
    if (chan_cfg == '0) begin
      nc_eff = NC_W'(1);
    end else if (chan_cfg > NC_W'(MAX_CHANNELS)) begin
      nc_eff = NC_W'(MAX_CHANNELS);
    end else begin
      nc_eff = chan_cfg;
    end
    nb_eff = (bkt_cfg == '0) ? BKT_W'(1) : bkt_cfg;
    nf_eff = (frm_cfg == '0) ? FRM_W'(1) : frm_cfg;
  end

  assign samples.ready = (state == S_IDLE);
  assign in_acc        = samples.valid && samples.ready;

  // Divider requests: truncating divide of |sum| by the channel count, then
  // bucket placement. The bucket quotient stays below nb_eff, so the upper
  // product bits start out as the partial remainder.
  always_comb begin
    sum_mag = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
    div_req.start = (state == S_MGO) || (state == S_BGO);
    if (state == S_MGO) begin
      div_req.rem_init = '0;
      div_req.dvd_init = DVD_W'(sum_mag);
      div_req.divisor  = FRM_W'(nc_eff);
      div_req.steps    = STEP_W'(MAG_W);
    end else begin
      div_req.rem_init = prod[PROD_W-1:BKT_W];
      div_req.dvd_init = DVD_W'(prod[BKT_W-1:0]) << (DVD_W - BKT_W);
      div_req.divisor  = nf_eff;
      div_req.steps    = STEP_W'(BKT_W);
    end
  end

  // Clamp the mono magnitude to full scale, then restore the sign.
  always_comb begin
    q_mag    = div_rsp.quot[MAG_W-1:0];
    mono_mag = (q_mag > MAG_W'(FULL_SCALE_I)) ? SAMPLE_BITS'(FULL_SCALE_I)
                                               : SAMPLE_BITS'(q_mag);
    mono_val = sum[SUM_W-1] ? -mono_mag : mono_mag;
    bq       = div_rsp.quot[BKT_W-1:0];
    b_clamp  = (bq >= nb_eff) ? (nb_eff - BKT_W'(1)) : bq;
  end

  // Bucket bookkeeping for the frame: how many results it causes.
  always_comb begin
    adv      = bkt > open_bkt;
    last     = ({1'b0, pos} + (FRM_W + 1)'(1)) >= {1'b0, nf_eff};
    open_new = adv ? bkt : open_bkt;
    a_cnt    = adv ? (bkt - open_bkt) : '0;
    b_cnt    = last ? (nb_eff - open_new) : '0;
    total    = {1'b0, a_cnt} + {1'b0, b_cnt};
    n_sel    = (total > (BKT_W + 1)'(RESULT_LIMIT)) ? CNT_W'(RESULT_LIMIT)
                                                    : total[CNT_W-1:0];
    min_upd  = (mono < run_min) ? mono : run_min;
    max_upd  = (mono > run_max) ? mono : run_max;
  end

  // A result moves into the output register when it is empty or draining.
  always_comb begin
    load     = !ovalid || results.ready;
    idx_inc  = idx + BKT_W'(1);
    seg_done = (idx_inc == seg_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      chan_cfg <= CHANNELS_RST;
      bkt_cfg  <= BUCKETS_RST;
      frm_cfg  <= FRAMES_RST;
      pos      <= '0;
      prod     <= '0;
      open_bkt <= '0;
      run_min  <= SAMPLE_BITS'(FULL_SCALE_I);
      run_max  <= -SAMPLE_BITS'(FULL_SCALE_I);
      finished <= 1'b0;
      ovalid   <= 1'b0;
    end else begin
      // Drop the result beat once it is taken, unless the next one moves in.
      if (results.ready && !((state == S_EMIT) && load)) begin
        ovalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            smp[0] <= samples.sample_0;
            smp[1] <= samples.sample_1;
            smp[2] <= samples.sample_2;
            smp[3] <= samples.sample_3;
            smp[4] <= samples.sample_4;
            smp[5] <= samples.sample_5;
            smp[6] <= samples.sample_6;
            smp[7] <= samples.sample_7;
            ch     <= '0;
            sum    <= '0;
            // Frames past the end of the recording are swallowed.
            if (!finished) begin
              state <= S_SUM;
            end
          end
        end

        S_SUM: begin
          sum <= sum + SUM_W'(smp[ch]);
          ch  <= ch + CH_W'(1);
          if (NC_W'(ch) == (nc_eff - NC_W'(1))) begin
            state <= S_MGO;
          end
        end

        S_MGO: begin
          state <= S_MWAIT;
        end

        S_MWAIT: begin
          if (div_rsp.done) begin
            mono  <= mono_val;
            state <= S_BGO;
          end
        end

        S_BGO: begin
          state <= S_BWAIT;
        end

        S_BWAIT: begin
          if (div_rsp.done) begin
            bkt   <= b_clamp;
            state <= S_UPD;
          end
        end

        S_UPD: begin
          // Closed bucket and its empty followers carry the old extremes.
          seg_min <= run_min;
          seg_max <= run_max;
          if (adv) begin
            open_bkt <= bkt;
            run_min  <= mono;
            run_max  <= mono;
          end else begin
            run_min <= min_upd;
            run_max <= max_upd;
          end
          pos       <= pos + FRM_W'(1);
          prod      <= prod + PROD_W'(nb_eff);
          finished  <= last;
          last_f    <= last;
          phase_b   <= !adv;
          idx       <= open_bkt;
          seg_start <= open_bkt;
          seg_end   <= adv ? bkt : nb_eff;
          n_tot     <= n_sel;
          ovf       <= total > (BKT_W + 1)'(RESULT_LIMIT);
          cnt       <= '0;
          state     <= (total == '0) ? S_IDLE : S_EMIT;
        end

        S_EMIT: begin
          if (load) begin
            res_index    <= idx;
            res_min      <= phase_b ? run_min : seg_min;
            res_max      <= phase_b ? run_max : seg_max;
            res_filled   <= idx != seg_start;
            res_final    <= idx == (nb_eff - BKT_W'(1));
            res_run_last <= cnt == (n_tot - CNT_W'(1));
            res_ovf      <= ovf;
            ovalid       <= 1'b1;
            cnt          <= cnt + CNT_W'(1);
            // After the closing run, switch to the trailing run on the
            // last frame; it starts at the newly opened bucket.
            if (seg_done && !phase_b && last_f) begin
              phase_b   <= 1'b1;
              idx       <= open_bkt;
              seg_start <= open_bkt;
              seg_end   <= nb_eff;
            end else begin
              idx <= idx_inc;
            end
            // Results past the limit are never loaded.
            if (cnt == (n_tot - CNT_W'(1))) begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // A register write restarts the stream.
      if (cfg_hit) begin
        case (cfg_index)
          CFG_CHANNELS: chan_cfg <= cfg_data[NC_W-1:0];
          CFG_BUCKETS:  bkt_cfg  <= cfg_data[BKT_W-1:0];
          CFG_FRAMES:   frm_cfg  <= cfg_data[FRM_W-1:0];
          default:      chan_cfg <= chan_cfg;
        endcase
        pos      <= '0;
        prod     <= '0;
        open_bkt <= '0;
        run_min  <= SAMPLE_BITS'(FULL_SCALE_I);
        run_max  <= -SAMPLE_BITS'(FULL_SCALE_I);
        finished <= 1'b0;
      end
    end
  end

  assign results.valid        = ovalid;
  assign results.bucket_index = res_index;
  assign results.min_value    = res_min;
  assign results.max_value    = res_max;
  assign results.filled       = res_filled;
  assign results.final_bucket = res_final;
  assign results.run_last     = res_run_last;
  assign results.overflow     = res_ovf;

endmodule
